FILE: design/mpe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot pixel escape block.
package mpe_pkg;

  // Q8.28 orbit and point values
  localparam int Q_W    = 36;
  localparam int FRAC_W = 28;
  // Multiplier operand: |x|, |y| < 2 leaves 30 signed bits
  localparam int MUL_W  = FRAC_W + 2;
  localparam int PROD_W = 2 * MUL_W;

  localparam int CFG_W     = 13;
  localparam int CNT_OUT_W = 10;
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic signed [Q_W-1:0] Q_MAX = 36'sh7_FFFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 36'sh8_0000_0000;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  // Register index, taken from paddr bit 2
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [COLOR_W-1:0] C_0   = 8'd0;
  localparam logic [COLOR_W-1:0] C_102 = 8'd102;
  localparam logic [COLOR_W-1:0] C_150 = 8'd150;
  localparam logic [COLOR_W-1:0] C_154 = 8'd154;
  localparam logic [COLOR_W-1:0] C_200 = 8'd200;
  localparam logic [COLOR_W-1:0] C_205 = 8'd205;
  localparam logic [COLOR_W-1:0] C_238 = 8'd238;
  localparam logic [COLOR_W-1:0] C_255 = 8'd255;

  localparam logic AXIS_RE = 1'b0;
  localparam logic AXIS_IM = 1'b1;

  typedef struct packed {
    logic load;       // latch pixel coordinates
    logic div_init;   // start mapping division for current axis
    logic div_step;   // one quotient bit
    logic c_store;    // store mapped point; imaginary axis also clears orbit
    logic axis;
    logic iter_step;  // one orbit iteration
    logic out_load;   // capture result word
  } mpe_cmd_t;

  typedef struct packed {
    logic div_last;
    logic iter_stop;
  } mpe_sts_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W:0] v);
    logic signed [Q_W-1:0] r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = v[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/mpe_ctrl.sv
// Sequencer for the pixel escape block: mapping, orbit loop and result handoff.
module mpe_ctrl import mpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mpe_cmd_t cmd,
  input  mpe_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV_RUN,
    S_DIV_CAP,
    S_ITER,
    S_RESULT
  } state_t;

  state_t state_r;
  logic   axis_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd      = '0;
    cmd.axis = axis_r;
    case (state_r)
      S_IDLE:     cmd.load      = in_valid;
      S_DIV_INIT: cmd.div_init  = 1'b1;
      S_DIV_RUN:  cmd.div_step  = 1'b1;
      S_DIV_CAP:  cmd.c_store   = 1'b1;
      S_ITER:     cmd.iter_step = 1'b1;
      S_RESULT:   cmd.out_load  = !out_valid_r || out_ready;
      default:    cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_RE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_RESULT) && cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            axis_r  <= AXIS_RE;
            state_r <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: state_r <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (sts.div_last) begin
            state_r <= S_DIV_CAP;
          end
        end
        S_DIV_CAP: begin
          if (axis_r == AXIS_RE) begin
            axis_r  <= AXIS_IM;
            state_r <= S_DIV_INIT;
          end else begin
            state_r <= S_ITER;
          end
        end
        S_ITER: begin
          if (sts.iter_stop) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          // hand over once the output word is free
          if (cmd.out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/mpe_dp.sv
// Datapath: pixel-to-plane mapping divider, orbit iteration and band color.
module mpe_dp import mpe_pkg::*; #(
  parameter int MAX_ITER   = 1000,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  mpe_cmd_t              cmd,
  output mpe_sts_t              sts,
  input  logic [COORD_BITS-1:0] in_pixel_col,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  input  logic [CFG_W-1:0]      image_width,
  input  logic [CFG_W-1:0]      image_height,
  output logic [CNT_OUT_W-1:0]  out_iter_count,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue
);

  // half span is at most 12 bits, so the offset magnitude needs this many
  localparam int MAG_W  = (COORD_BITS > CFG_W - 1) ? COORD_BITS : CFG_W - 1;
  localparam int OFF_W  = MAG_W + 1;
  localparam int DVD_W  = MAG_W + FRAC_W + 2;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int CNT_W  = $clog2(MAX_ITER + 1);
  localparam int HI_W   = DVD_W - Q_W + 1;

  localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(MAX_ITER);
  localparam logic [CNT_W-1:0] LIM_10  = CNT_W'(MAX_ITER / 10);
  localparam logic [CNT_W-1:0] LIM_8   = CNT_W'(MAX_ITER / 8);
  localparam logic [CNT_W-1:0] LIM_6   = CNT_W'(MAX_ITER / 6);
  localparam logic [CNT_W-1:0] LIM_4   = CNT_W'(MAX_ITER / 4);
  localparam logic [CNT_W-1:0] LIM_2   = CNT_W'(MAX_ITER / 2);

  logic [COORD_BITS-1:0] col_r, row_r;

  // ---- mapping: off * 2^30 / width, one quotient bit a cycle
  logic [CFG_W-1:0]      w_eff;
  logic [COORD_BITS-1:0] pos;
  logic [CFG_W-1:0]      span;
  logic [OFF_W-1:0]      off, off_neg;
  logic [MAG_W-1:0]      mag;

  logic [DVD_W-1:0]  dvd_r, quo_r;
  logic [CFG_W-1:0]  rem_r;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [CFG_W:0]    rem_sh, rem_sub;
  logic              q_bit;
  logic [CFG_W-1:0]  rem_nxt;

  logic [HI_W-1:0]       q_hi;
  logic [Q_W-1:0]        q_lo;
  logic                  pos_over, neg_over;
  logic signed [Q_W-1:0] c_val;

  assign w_eff   = (image_width == '0) ? CFG_W'(1) : image_width;
  assign pos     = (cmd.axis == AXIS_IM) ? row_r : col_r;
  assign span    = (cmd.axis == AXIS_IM) ? image_height : w_eff;
  assign off     = OFF_W'(pos) - OFF_W'(span[CFG_W-1:1]);
  assign off_neg = -off;
  assign mag     = off[OFF_W-1] ? off_neg[MAG_W-1:0] : off[MAG_W-1:0];

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, w_eff};
  assign q_bit   = (rem_sh >= {1'b0, w_eff});
  assign rem_nxt = q_bit ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];

  assign sts.div_last = (dcnt_r == DCNT_W'(DVD_W - 1));

  // saturate the truncated quotient to Q8.28
  assign q_hi     = quo_r[DVD_W-1:Q_W-1];
  assign q_lo     = quo_r[Q_W-1:0];
  assign pos_over = |q_hi;
  assign neg_over = pos_over &&
                    !((q_hi == HI_W'(1)) && (quo_r[Q_W-2:0] == '0));
  assign c_val    = neg_r ? (neg_over ? Q_MIN : -signed'(q_lo))
                          : (pos_over ? Q_MAX : signed'(q_lo));

  // ---- orbit
  logic signed [Q_W-1:0]    x_r, y_r, cr_r, ci_r;
  logic [CNT_W-1:0]         n_r;
  logic signed [MUL_W-1:0]  xs, ys;
  logic signed [PROD_W-1:0] xx, yy, xy, diff;
  logic [PROD_W-2:0]        sq;
  logic [Q_W-MUL_W:0]       x_top, y_top;
  logic                     esc_x, esc_y, big, cnt_max;
  logic signed [Q_W:0]      nx_full, ny_full;
  logic signed [Q_W-1:0]    nx, ny;

  assign x_top = x_r[Q_W-1:MUL_W-1];
  assign y_top = y_r[Q_W-1:MUL_W-1];
  // |v| < 2 exactly when v fits in MUL_W signed bits and is not the minimum
  assign esc_x = !((x_top == '0) || ((&x_top) && (|x_r[MUL_W-2:0])));
  assign esc_y = !((y_top == '0) || ((&y_top) && (|y_r[MUL_W-2:0])));

  assign xs = x_r[MUL_W-1:0];
  assign ys = y_r[MUL_W-1:0];
  assign xx = xs * xs;
  assign yy = ys * ys;
  assign xy = xs * ys;

  assign sq      = {1'b0, xx[PROD_W-3:0]} + {1'b0, yy[PROD_W-3:0]};
  assign big     = sq[PROD_W-2];
  assign cnt_max = (n_r >= LIM_MAX);
  assign sts.iter_stop = cnt_max || esc_x || esc_y || big;

  // arithmetic shift of the exact product is the floor
  assign diff    = xx - yy;
  assign nx_full = (Q_W+1)'(signed'(diff[PROD_W-1:FRAC_W])) + (Q_W+1)'(cr_r);
  assign ny_full = (Q_W+1)'(signed'(xy[PROD_W-1:FRAC_W-1])) + (Q_W+1)'(ci_r);
  assign nx      = sat_q(nx_full);
  assign ny      = sat_q(ny_full);

  // ---- band color
  logic [COLOR_W-1:0] r_c, g_c, b_c;

  always_comb begin
    r_c = C_0;
    g_c = C_0;
    b_c = C_0;
    if (n_r < LIM_10) begin
      g_c = C_205;
    end else if (n_r < LIM_8) begin
      g_c = C_238;
    end else if (n_r == LIM_6) begin
      r_c = C_102;
      g_c = C_205;
    end else if (n_r == LIM_4) begin
      r_c = C_154;
      g_c = C_255;
      b_c = C_154;
    end else if (n_r == LIM_2) begin
      g_c = C_255;
      b_c = C_150;
    end else if (n_r < LIM_MAX) begin
      g_c = C_255;
      b_c = C_200;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
    if (cmd.div_init) begin
      dvd_r  <= {mag, {(FRAC_W + 2){1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
      neg_r  <= off[OFF_W-1];
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[DVD_W-2:0], q_bit};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.c_store) begin
      if (cmd.axis == AXIS_RE) begin
        cr_r <= c_val;
      end else begin
        ci_r <= c_val;
        x_r  <= '0;
        y_r  <= '0;
        n_r  <= '0;
      end
    end else if (cmd.iter_step && !sts.iter_stop) begin
      x_r <= nx;
      y_r <= ny;
      n_r <= n_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_iter_count <= CNT_OUT_W'(n_r);
      out_red        <= r_c;
      out_green      <= g_c;
      out_blue       <= b_c;
    end
  end

endmodule

FILE: design/mandelbrot_pixel_escape.sv
// Mandelbrot escape-time pixel evaluator, top level with configuration registers.
//
// Each word on the in_ channel names a pixel; one word on the out_ channel
// returns its escape count and band color. The block handles one pixel at a
// time. The mapping divider yields one quotient bit a cycle and runs once per
// axis, and the orbit loop does one iteration a cycle on a set of three 30x30
// multipliers until the point escapes or the count reaches MAX_ITER.
// A finished word waits in the output register while the next pixel is
// taken. image_width and image_height sit at byte addresses 0x0 and 0x4 and
// must only be written while no pixel is in flight.
module mandelbrot_pixel_escape import mpe_pkg::*; #(
  parameter int MAX_ITER   = 1000,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_col,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_OUT_W-1:0]  out_iter_count,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  output logic [DATA_W-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [CFG_W-1:0] width_r, height_r;
  mpe_cmd_t         cmd;
  mpe_sts_t         sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_HEIGHT) ? DATA_W'(height_r)
                                                       : DATA_W'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_IDX_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_IDX_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default:        width_r  <= width_r;
      endcase
    end
  end

  mpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mpe_dp #(
    .MAX_ITER   (MAX_ITER),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .image_width    (width_r),
    .image_height   (height_r),
    .out_iter_count (out_iter_count),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule

FILE: design/mpe_checker.sv
// Port-level checks for the pixel escape block, bound to the top level.
module mpe_checker import mpe_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CNT_OUT_W-1:0] out_iter_count,
  input logic [COLOR_W-1:0]   out_red,
  input logic [COLOR_W-1:0]   out_green,
  input logic [COLOR_W-1:0]   out_blue
);

  // reset drops any pending word
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iter_count))
    else $error("result word dropped or changed while stalled");

  // one pixel at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new word taken while a pixel is in flight");

  // an immediate escape is always the first band
  a_first_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_iter_count == '0) |->
      (out_red == C_0) && (out_green == C_205) && (out_blue == C_0))
    else $error("wrong color for zero count");

endmodule

bind mandelbrot_pixel_escape mpe_checker u_mpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_iter_count (out_iter_count),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue)
);

FILE: tb/tb_top.sv
// Self-checking testbench for mandelbrot_pixel_escape: directed and random pixels vs fixed-point escape model.
module tb_top;
  import mpe_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int TIMEOUT      = 40_000_000;
  localparam int MAX_ITER     = 1000;
  localparam int COORD_BITS   = 12;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int CFG_MAX      = (1 << CFG_W) - 1;
  localparam int GAP_MAX      = 11;
  localparam int HOLD_AT      = 150;
  localparam int LONG_HOLD    = 2500;
  localparam int DRAIN_CYCLES = 1200;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 100;

  localparam int BAND_LOW     = MAX_ITER / 10;
  localparam int BAND_MID     = MAX_ITER / 8;
  localparam int BAND_SIXTH   = MAX_ITER / 6;
  localparam int BAND_QUARTER = MAX_ITER / 4;
  localparam int BAND_HALF    = MAX_ITER / 2;

  localparam longint TWO_Q   = 64'sd1 <<< (FRAC_W + 1);
  localparam longint FOUR_Q2 = 64'sd1 <<< (2 * FRAC_W + 2);
  localparam longint QV_MAX  = (64'sd1 <<< (Q_W - 1)) - 1;
  localparam longint QV_MIN  = -(64'sd1 <<< (Q_W - 1));

  localparam logic [ADDR_W-1:0] ADDR_WIDTH  = {REG_IDX_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_HEIGHT = {REG_IDX_HEIGHT, 2'b00};

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] iter_count;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } shade_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] in_pixel_col = '0;
  logic [COORD_BITS-1:0] in_pixel_row = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [CNT_OUT_W-1:0]  out_iter_count;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic                  cfg_psel     = 1'b0;
  logic                  cfg_penable  = 1'b0;
  logic                  cfg_pwrite   = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr    = '0;
  logic [DATA_W-1:0]     cfg_pwdata   = '0;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // register copies used for prediction
  logic [CFG_W-1:0] width_reg  = WIDTH_RST;
  logic [CFG_W-1:0] height_reg = HEIGHT_RST;

  pixel_t      pixel_fifo[$];
  shade_t      shade_fifo[$];
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned n_offered  = 0;
  int unsigned n_results  = 0;
  int unsigned n_capped   = 0;
  int unsigned n_errors   = 0;
  int unsigned n_settings = 0;

  mandelbrot_pixel_escape #(.MAX_ITER(MAX_ITER), .COORD_BITS(COORD_BITS)) DUT (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint clamp_q(input longint v);
    if (v > QV_MAX) return QV_MAX;
    if (v < QV_MIN) return QV_MIN;
    return v;
  endfunction

  // quotient truncates toward zero, then clamps to Q8.28
  function automatic longint axis_to_q(input int pos, input int span, input int scale);
    longint off;
    off = longint'(pos) - longint'(span / 2);
    return clamp_q((off * (64'sd4 <<< FRAC_W)) / longint'(scale));
  endfunction

  function automatic int escape_len(input longint cr, input longint ci);
    longint x, y, xx, yy, nx, ny;
    int     n;
    bit     done;
    x = 0;
    y = 0;
    n = 0;
    done = 1'b0;
    while (!done && n < MAX_ITER) begin
      if ((x < 0 ? -x : x) >= TWO_Q || (y < 0 ? -y : y) >= TWO_Q) begin
        done = 1'b1;
      end else begin
        xx = x * x;
        yy = y * y;
        if (xx + yy >= FOUR_Q2) begin
          done = 1'b1;
        end else begin
          // arithmetic shift floors the rescaled product
          nx = clamp_q(((xx - yy) >>> FRAC_W) + cr);
          ny = clamp_q(((2 * x * y) >>> FRAC_W) + ci);
          x = nx;
          y = ny;
          n++;
        end
      end
    end
    return n;
  endfunction

  function automatic shade_t shade_of_pixel(input pixel_t px, input logic [CFG_W-1:0] w_reg,
                                            input logic [CFG_W-1:0] h_reg);
    shade_t s;
    int     w, n;
    w = (w_reg == 0) ? 1 : int'(w_reg);
    n = escape_len(axis_to_q(px.col, w, w), axis_to_q(px.row, int'(h_reg), w));
    s.iter_count = n[CNT_OUT_W-1:0];
    if (n < BAND_LOW) begin
      {s.red, s.green, s.blue} = {C_0, C_205, C_0};
    end else if (n < BAND_MID) begin
      {s.red, s.green, s.blue} = {C_0, C_238, C_0};
    end else if (n == BAND_SIXTH) begin
      {s.red, s.green, s.blue} = {C_102, C_205, C_0};
    end else if (n == BAND_QUARTER) begin
      {s.red, s.green, s.blue} = {C_154, C_255, C_154};
    end else if (n == BAND_HALF) begin
      {s.red, s.green, s.blue} = {C_0, C_255, C_150};
    end else if (n < MAX_ITER) begin
      {s.red, s.green, s.blue} = {C_0, C_255, C_200};
    end else begin
      {s.red, s.green, s.blue} = {C_0, C_0, C_0};
    end
    return s;
  endfunction

  // Just right of the cusp at c = 1/4 on the real axis the count rises smoothly
  // as c closes in; sweep widths there until one pixel lands exactly on n.
  function automatic bit find_cusp_pixel(input int n, output int w_found, output int col_found);
    int w, d, cnt;
    bit hit;
    hit = 1'b0;
    w_found = 0;
    col_found = 0;
    for (w = 7280; w >= 2000 && !hit; w--) begin
      d = w / 16 + 1;
      cnt = MAX_ITER;
      while (!hit && cnt > n && w / 2 + d <= COORD_MAX) begin
        cnt = escape_len(axis_to_q(w / 2 + d, w, w), 0);
        if (cnt == n) begin
          hit = 1'b1;
          w_found = w;
          col_found = w / 2 + d;
        end
        d++;
      end
    end
    return hit;
  endfunction

  // every fourth stretch of 32 words runs back to back
  function automatic int unsigned idle_draw(input int unsigned k);
    return ((k / 32) % 4 == 3) ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic pixel_t make_pixel(input int c, input int r);
    pixel_t p;
    p.col = c[COORD_BITS-1:0];
    p.row = r[COORD_BITS-1:0];
    return p;
  endfunction

  function automatic int span_of(input int unsigned v);
    if (v == 0) return 1;
    return (v > COORD_MAX + 1) ? COORD_MAX + 1 : int'(v);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        shade_fifo.push_back(shade_of_pixel({in_pixel_col, in_pixel_row}, width_reg, height_reg));
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_fifo.size() != 0) begin
        in_valid     <= 1'b1;
        in_pixel_col <= pixel_fifo[0].col;
        in_pixel_row <= pixel_fifo[0].row;
        void'(pixel_fifo.pop_front());
        gap_left <= idle_draw(n_offered);
        n_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    shade_t      want;
    int unsigned stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall = stall_left;
      if (out_valid && out_ready) begin
        if (shade_fifo.size() == 0) begin
          $display("%0t: unexpected word: count %0d, rgb %0d/%0d/%0d", $time, out_iter_count,
                   out_red, out_green, out_blue);
          n_errors++;
        end else begin
          want = shade_fifo.pop_front();
          check_field("iter_count", want.iter_count, out_iter_count);
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
        end
        n_results++;
        if (out_iter_count == MAX_ITER) n_capped++;
        // hold off once for a long stretch so the block backs up into its input
        stall = (n_results == HOLD_AT) ? LONG_HOLD : idle_draw(n_results + 16);
      end
      if (stall != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    rdata = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_reg(input logic [ADDR_W-1:0] addr, input int unsigned value);
    logic [DATA_W-1:0] wdata, got, unused;
    logic [CFG_W-1:0]  v;
    v = value[CFG_W-1:0];
    // upper bits carry noise; the register keeps only its low bits
    wdata = $urandom();
    wdata[CFG_W-1:0] = v;
    apb_xfer(1'b1, addr, wdata, unused);
    if (addr == ADDR_WIDTH) width_reg = v;
    else height_reg = v;
    apb_xfer(1'b0, addr, '0, got);
    if (got != {{(DATA_W - CFG_W){1'b0}}, v}) begin
      $display("%0t: readback at 0x%0h: expected %0d, got %0d", $time, addr, v, got);
      n_errors++;
    end
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h);
    set_reg(ADDR_WIDTH, w);
    set_reg(ADDR_HEIGHT, h);
    n_settings++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_fifo.size() != 0 || in_valid || shade_fifo.size() != 0);
  endtask

  initial begin : stimulus
    int          w_hit, col_hit, n_band_hits;
    int unsigned w, h;
    int          targets[3];
    n_band_hits = 0;
    targets = '{BAND_SIXTH, BAND_QUARTER, BAND_HALF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry 640 x 480: corners, origin, real-axis landmarks
    pixel_fifo.push_back(make_pixel(0, 0));
    pixel_fifo.push_back(make_pixel(COORD_MAX, COORD_MAX));
    pixel_fifo.push_back(make_pixel(COORD_MAX, 0));
    pixel_fifo.push_back(make_pixel(0, COORD_MAX));
    pixel_fifo.push_back(make_pixel(320, 240));
    pixel_fifo.push_back(make_pixel(0, 240));
    pixel_fifo.push_back(make_pixel(160, 240));
    pixel_fifo.push_back(make_pixel(400, 240));
    pixel_fifo.push_back(make_pixel(200, 224));
    wait_idle();
    n_settings++;

    // zero width acts as one; far pixels saturate the mapped point
    set_config(0, 0);
    pixel_fifo.push_back(make_pixel(0, 0));
    pixel_fifo.push_back(make_pixel(COORD_MAX, 0));
    wait_idle();
    set_config(0, CFG_MAX);
    pixel_fifo.push_back(make_pixel(0, 0));
    pixel_fifo.push_back(make_pixel(COORD_MAX, COORD_MAX));
    wait_idle();

    set_config(1, 1);
    pixel_fifo.push_back(make_pixel(0, 0));
    pixel_fifo.push_back(make_pixel(1, 1));
    pixel_fifo.push_back(make_pixel(COORD_MAX, COORD_MAX));
    wait_idle();

    set_config(CFG_MAX, CFG_MAX);
    pixel_fifo.push_back(make_pixel(0, 0));
    pixel_fifo.push_back(make_pixel(COORD_MAX, COORD_MAX));
    pixel_fifo.push_back(make_pixel(2047, COORD_MAX));
    wait_idle();

    // counts that hit the exact-equality color bands
    foreach (targets[t]) begin
      if (find_cusp_pixel(targets[t], w_hit, col_hit)) begin
        set_config(w_hit, 0);
        pixel_fifo.push_back(make_pixel(col_hit, 0));
        wait_idle();
        n_band_hits++;
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          w = $urandom_range(32, 1024);
          h = $urandom_range(w / 2, w);
        end
        3: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(0, 32);
        end
        4: begin
          w = $urandom_range(2048, CFG_MAX);
          h = $urandom_range(0, CFG_MAX);
        end
        default: begin
          w = $urandom_range(0, CFG_MAX);
          h = $urandom_range(0, CFG_MAX);
        end
      endcase
      set_config(w, h);
      // mostly pixels inside the image, the rest anywhere in the coordinate range
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          pixel_fifo.push_back(make_pixel($urandom_range(0, span_of(w) - 1),
                                          $urandom_range(0, span_of(h) - 1)));
        end else begin
          pixel_fifo.push_back(make_pixel($urandom_range(0, COORD_MAX),
                                          $urandom_range(0, COORD_MAX)));
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d pixel words (%0d at the iteration cap) over %0d register settings.",
             n_results, n_capped, n_settings);
    $display("Exact band-boundary counts placed: %0d of 3; mismatches: %0d.",
             n_band_hits, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("%0t: timeout with %0d words outstanding", $time, shade_fifo.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/mpe_pkg.sv
design/mpe_ctrl.sv
design/mpe_dp.sv
design/mandelbrot_pixel_escape.sv
design/mpe_checker.sv
tb/tb_top.sv
